// ----- src/acvp_pkg.sv -----
// Shared constants and types for the ASCII channel/value frame parser.
package acvp_pkg;

    // Accumulator width; the digit magnitude limit is 2^(VALUE_BITS-1)-1
    localparam int VALUE_BITS = 32;
    localparam int MAG_W      = VALUE_BITS - 1;
    localparam int PROD_W     = MAG_W + 4;
    localparam int OUT_W      = 32;
    localparam int NEG_W      = (VALUE_BITS > OUT_W) ? VALUE_BITS : OUT_W;

    localparam logic [MAG_W-1:0]  MAG_LIMIT  = {MAG_W{1'b1}};
    localparam logic [PROD_W-1:0] PROD_LIMIT = {{(PROD_W-MAG_W){1'b0}}, MAG_LIMIT};

    // Characters of the frame grammar
    localparam logic [7:0] CH_START = 8'h50; // 'P'
    localparam logic [7:0] CH_A     = 8'h41; // 'A'
    localparam logic [7:0] CH_D     = 8'h44; // 'D'
    localparam logic [7:0] CH_END   = 8'h21; // '!'
    localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CH_NINE  = 8'h39; // '9'

    // Parse phases
    typedef logic [2:0] t_phase;
    localparam t_phase PH_IDLE  = 3'd0; // hunting for start character
    localparam t_phase PH_CHAN  = 3'd1; // start seen, expecting channel letter
    localparam t_phase PH_FIRST = 3'd2; // letter seen, expecting sign, digit or end
    localparam t_phase PH_BODY  = 3'd3; // expecting digit or end

endpackage

// ----- src/ascii_channel_value_parser.sv -----
// Top level: ASCII frame parser "P<A-D>[-]<digits>!" giving channel and value in tenths.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------------
//  rx      | i_rx_valid / o_rx_ready   | i_rx_byte[7:0]
//  result  | o_out_valid / i_out_ready | o_channel[1:0], o_value_tenths[31:0], o_clipped
//
// One byte per cycle sustained. A beat is registered at the input and then parsed by
// a single add/compare pass (magnitude*10 + digit against the limit); a completed
// frame lands in the output register at the end of the cycle in which its '!' is parsed.
// The pipeline stalls only while a result sits in the output register unread.
// Synchronous active-low reset returns the parser to hunting for 'P'.
module ascii_channel_value_parser
    import acvp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rx_valid,
    output logic                    o_rx_ready,
    input  logic [7:0]              i_rx_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_channel,
    output logic signed [OUT_W-1:0] o_value_tenths,
    output logic                    o_clipped
);

    // Input register
    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte;

    // Frame state
    t_phase           r_phase, n_phase;
    logic [1:0]       r_chan, n_chan;
    logic             r_minus, n_minus;
    logic             r_digit, n_digit;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic             r_clip, n_clip;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_chan;
    logic [OUT_W-1:0] r_out_value;
    logic             r_out_clip;

    logic             advance, take, emit;
    logic [7:0]       b;
    logic [3:0]       dig;
    logic             is_digit, is_letter;
    logic [PROD_W-1:0] prod;
    logic [NEG_W-1:0] mag_ext, signed_val;

    // Stage advances unless a result is stuck in the output register
    assign advance    = !r_out_valid || i_out_ready;
    assign take       = r_in_valid && advance;
    assign o_rx_ready = !r_in_valid || advance;

    assign b         = r_in_byte;
    assign dig       = 4'(b - CH_ZERO);
    assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_letter = (b >= CH_A) && (b <= CH_D);

    // magnitude*10 + digit as shift-adds
    assign prod = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                + {{(PROD_W-4){1'b0}}, dig};

    // Signed value, low bits kept
    assign mag_ext    = {{(NEG_W-MAG_W){1'b0}}, r_mag};
    assign signed_val = r_minus ? (~mag_ext + 1'b1) : mag_ext;

    // Parse one byte
    always_comb begin
        n_phase = r_phase;
        n_chan  = r_chan;
        n_minus = r_minus;
        n_digit = r_digit;
        n_mag   = r_mag;
        n_clip  = r_clip;
        emit    = 1'b0;
        if (take) begin
            unique case (r_phase)
                PH_CHAN: begin
                    if (is_letter) begin
                        n_chan  = 2'(b - CH_A);
                        n_phase = PH_FIRST;
                    end else begin
                        n_phase = (b == CH_START) ? PH_CHAN : PH_IDLE;
                        n_chan  = '0;
                        n_minus = 1'b0;
                        n_digit = 1'b0;
                        n_mag   = '0;
                        n_clip  = 1'b0;
                    end
                end
                PH_FIRST, PH_BODY: begin
                    if (b == CH_END) begin
                        // End of frame: result only if digits were seen
                        emit    = r_digit;
                        n_phase = PH_IDLE;
                        n_chan  = '0;
                        n_minus = 1'b0;
                        n_digit = 1'b0;
                        n_mag   = '0;
                        n_clip  = 1'b0;
                    end else if ((b == CH_MINUS) && (r_phase == PH_FIRST)) begin
                        n_minus = 1'b1;
                        n_phase = PH_BODY;
                    end else if (is_digit) begin
                        if (prod > PROD_LIMIT) begin
                            n_mag  = MAG_LIMIT;
                            n_clip = 1'b1;
                        end else begin
                            n_mag  = prod[MAG_W-1:0];
                        end
                        n_digit = 1'b1;
                        n_phase = PH_BODY;
                    end else begin
                        n_phase = (b == CH_START) ? PH_CHAN : PH_IDLE;
                        n_chan  = '0;
                        n_minus = 1'b0;
                        n_digit = 1'b0;
                        n_mag   = '0;
                        n_clip  = 1'b0;
                    end
                end
                default: begin
                    // idle and unused codes
                    n_phase = (b == CH_START) ? PH_CHAN : PH_IDLE;
                    n_chan  = '0;
                    n_minus = 1'b0;
                    n_digit = 1'b0;
                    n_mag   = '0;
                    n_clip  = 1'b0;
                end
            endcase
        end
    end

    // Handshake next values
    always_comb begin
        n_in_valid  = o_rx_ready ? i_rx_valid : r_in_valid;
        n_out_valid = advance ? emit : r_out_valid;
    end

    // Control and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_chan      <= '0;
            r_minus     <= 1'b0;
            r_digit     <= 1'b0;
            r_mag       <= '0;
            r_clip      <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_chan      <= n_chan;
            r_minus     <= n_minus;
            r_digit     <= n_digit;
            r_mag       <= n_mag;
            r_clip      <= n_clip;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (emit) begin
            r_out_chan  <= r_chan;
            r_out_value <= signed_val[OUT_W-1:0];
            r_out_clip  <= r_clip;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_channel      = r_out_chan;
    assign o_value_tenths = r_out_value;
    assign o_clipped      = r_out_clip;

    // Checks on internal consistency
    a_clip_needs_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clip |-> r_digit)
        else $error("clip flag set without any digit");

    a_minus_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_minus |-> (r_phase == PH_BODY))
        else $error("minus flag outside frame body");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_IDLE) || (r_phase == PH_CHAN)) |-> (!r_digit && r_mag == '0))
        else $error("frame fields not cleared before letter");

    a_emit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> (!take ##1 r_out_valid))
        else $error("result lost or parser advanced under stall");

endmodule
